/* rtl/crwa_pkg.sv */
// Shared constants, types and control/status structs for the count rate window alarm.
package crwa_pkg;

  localparam int WINDOW_TICKS_DEF  = 60;
  localparam int HISTORY_DEPTH_DEF = 24 * 60;
  localparam int COUNT_BITS        = 16;
  localparam int RATE_W            = 22;
  localparam int LEVEL_W           = 26;
  localparam int FACTOR_W          = 4;
  localparam int PERIOD_W          = 6;
  localparam int CFG_DATA_W        = 6;
  localparam int CFG_IDX_W         = 1;

  localparam logic [RATE_W-1:0]     RATE_MAX       = {RATE_W{1'b1}};
  localparam logic [FACTOR_W-1:0]   FACTOR_RST     = FACTOR_W'(4);
  localparam logic [PERIOD_W-1:0]   PERIOD_RST     = PERIOD_W'(10);

  localparam logic [CFG_IDX_W-1:0]  CFG_THRESHOLD_FACTOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  CFG_REPORT_PERIOD    = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_GO,
    S_MOD_WAIT,
    S_HIST,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;      // take the input word, update ring and position
    logic div_start;
    logic div_sel;     // 0: position mod report period, 1: history mean
    logic report_ld;
    logic hist_upd;
    logic level_ld;
    logic out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wrap;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/crwa_div.sv */
// Iterative restoring divider, one quotient bit per cycle, shared for mod and mean.
module crwa_div #(
  parameter int DVD_W = 33,
  parameter int DVS_W = 11,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  input  logic [CNT_W-1:0] iters,
  output logic             busy,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iters;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/crwa_datapath.sv */
// Datapath: tick ring, history ring, running sums, config registers and result register.
module crwa_datapath #(
  parameter int WINDOW_TICKS  = crwa_pkg::WINDOW_TICKS_DEF,
  parameter int HISTORY_DEPTH = crwa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crwa_pkg::ctrl_cmd_t                 cmd,
  output crwa_pkg::dp_status_t                sts,
  input  logic                                cfg_we,
  input  logic [crwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crwa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [crwa_pkg::COUNT_BITS-1:0]     in_tick_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [crwa_pkg::RATE_W-1:0]         out_window_rate,
  output logic                                out_rate_valid,
  output logic                                out_report_due,
  output logic                                out_window_done,
  output logic [crwa_pkg::LEVEL_W-1:0]        out_alarm_level,
  output logic                                out_alarm
);

  localparam int CB     = crwa_pkg::COUNT_BITS;
  localparam int RW     = crwa_pkg::RATE_W;
  localparam int LW     = crwa_pkg::LEVEL_W;
  localparam int POS_W  = $clog2(WINDOW_TICKS);
  localparam int SUM_W  = CB + POS_W;
  localparam int CMP_W  = (SUM_W > RW) ? SUM_W : RW;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W  = RW + $clog2(HISTORY_DEPTH);
  localparam int DVS_W  = (FILL_W > crwa_pkg::PERIOD_W) ? FILL_W : crwa_pkg::PERIOD_W;
  localparam int CNT_W  = $clog2(TOT_W + 1);

  // config
  logic [crwa_pkg::FACTOR_W-1:0] factor_r;
  logic [crwa_pkg::PERIOD_W-1:0] period_r;

  // window state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              warm_r;
  logic              was_warm_r;
  logic              wrap_r;
  logic              wrap_now;
  logic [RW-1:0]     rate_r, rate_nxt;
  logic              report_r;

  // history state
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [LW-1:0]     level_r;

  // memories
  logic [CB-1:0] ring_mem [WINDOW_TICKS];
  logic [CB-1:0] ring_rd_r;
  logic [RW-1:0] hist_mem [HISTORY_DEPTH];
  logic [RW-1:0] hist_rd_r;
  logic [CB-1:0] old_tick;
  logic [RW-1:0] old_rate;

  // divider
  logic [TOT_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [CNT_W-1:0] div_iters;
  logic             div_busy;
  logic [TOT_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  // result register
  logic          out_valid_r;
  logic [RW-1:0] o_rate_r;
  logic          o_rvalid_r, o_report_r, o_done_r, o_alarm_r;
  logic [LW-1:0] o_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= crwa_pkg::FACTOR_RST;
      period_r <= crwa_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crwa_pkg::CFG_THRESHOLD_FACTOR: factor_r <= cfg_wdata[crwa_pkg::FACTOR_W-1:0];
        crwa_pkg::CFG_REPORT_PERIOD:    period_r <= cfg_wdata[crwa_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring entries are written in position order, so before the first wrap every
  // entry read is still unwritten and counts as zero.
  assign old_tick = warm_r ? ring_rd_r : '0;
  assign wrap_now = (pos_r == POS_W'(WINDOW_TICKS - 1));
  assign pos_nxt  = wrap_now ? '0 : pos_r + 1'b1;
  assign sum_nxt  = sum_r - SUM_W'(old_tick) + SUM_W'(in_tick_count);
  assign rate_nxt = (CMP_W'(sum_nxt) > CMP_W'(crwa_pkg::RATE_MAX)) ?
                    crwa_pkg::RATE_MAX : RW'(sum_nxt);

  // Same for history: slot tracks fill count until the history is full.
  assign old_rate  = (fill_r == FILL_W'(HISTORY_DEPTH)) ? hist_rd_r : '0;
  assign total_nxt = total_r - TOT_W'(old_rate) + TOT_W'(rate_r);
  assign slot_nxt  = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[pos_r] <= in_tick_count;
    end
    ring_rd_r <= ring_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_upd) begin
      hist_mem[slot_r] <= rate_r;
    end
    hist_rd_r <= hist_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      warm_r  <= 1'b0;
      slot_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
      level_r <= '0;
    end else begin
      if (cmd.accept) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
      if (cmd.hist_upd) begin
        warm_r  <= 1'b1;
        slot_r  <= slot_nxt;
        total_r <= total_nxt;
        if (fill_r != FILL_W'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.level_ld) begin
        level_r <= LW'(div_quo[RW-1:0]) * LW'(factor_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      was_warm_r <= warm_r;
      wrap_r     <= wrap_now;
      rate_r     <= rate_nxt;
    end
    if (cmd.report_ld) begin
      report_r <= was_warm_r && (period_r != '0) && (div_rem == '0);
    end
  end

  // position goes in left-aligned so that POS_W steps leave its remainder
  assign div_dvd   = cmd.div_sel ? total_r : {pos_r, {(TOT_W - POS_W){1'b0}}};
  assign div_dvs   = cmd.div_sel ? DVS_W'(fill_r) : DVS_W'(period_r);
  assign div_iters = cmd.div_sel ? CNT_W'(TOT_W) : CNT_W'(POS_W);

  crwa_div #(
    .DVD_W (TOT_W),
    .DVS_W (DVS_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .iters     (div_iters),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_rate_r   <= rate_r;
      o_rvalid_r <= warm_r;
      o_report_r <= report_r;
      o_done_r   <= wrap_r;
      o_level_r  <= level_r;
      o_alarm_r  <= (LW'(rate_r) > level_r);
    end
  end

  assign sts.wrap     = wrap_r;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_window_rate = o_rate_r;
  assign out_rate_valid  = o_rvalid_r;
  assign out_report_due  = o_report_r;
  assign out_window_done = o_done_r;
  assign out_alarm_level = o_level_r;
  assign out_alarm       = o_alarm_r;

endmodule

/* rtl/crwa_ctrl.sv */
// Controller: ring update, report check per word; history update, mean divide on a wrap.
module crwa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crwa_pkg::dp_status_t sts,
  output crwa_pkg::ctrl_cmd_t  cmd
);

  crwa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crwa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      crwa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = crwa_pkg::S_MOD_GO;
        end
      end
      crwa_pkg::S_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = crwa_pkg::S_MOD_WAIT;
      end
      crwa_pkg::S_MOD_WAIT: begin
        if (!sts.div_busy) begin
          cmd.report_ld = 1'b1;
          state_nxt     = sts.wrap ? crwa_pkg::S_HIST : crwa_pkg::S_OUT;
        end
      end
      crwa_pkg::S_HIST: begin
        cmd.hist_upd = 1'b1;
        state_nxt    = crwa_pkg::S_MEAN_GO;
      end
      crwa_pkg::S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = crwa_pkg::S_MEAN_WAIT;
      end
      crwa_pkg::S_MEAN_WAIT: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) begin
          cmd.level_ld = 1'b1;
          state_nxt    = crwa_pkg::S_OUT;
        end
      end
      crwa_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = crwa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = crwa_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != crwa_pkg::S_IDLE);

endmodule

/* rtl/count_rate_window_alarm.sv */
// Count rate window alarm: sliding-window event rate with a self-adjusting alarm level.
//
// Input channel (in_valid / in_stall): one word per tick, in_tick_count events.
// Result channel (out_valid / out_stall): one word per input word, in order:
// window rate over the last WINDOW_TICKS ticks, rate valid, report due,
// window done, current alarm level and the alarm flag.
// Config port: cfg_we with cfg_index 0 = threshold factor, 1 = report period;
// write only while the block is idle.
// Words are handled one at a time. An ordinary tick passes once through the
// shared bit-serial divider, which computes the position modulo the report
// period. A tick that closes a window also takes the history mean through the
// same divider. The next word is accepted as soon as its result is in the
// output register, even while out_stall holds that result; a stalled result
// blocks the following one from leaving the controller. Reset (rst_n low,
// synchronous) empties both rings, clears sums, level and output valid, and
// restores factor 4, period 10.
module count_rate_window_alarm #(
  parameter int WINDOW_TICKS  = crwa_pkg::WINDOW_TICKS_DEF,
  parameter int HISTORY_DEPTH = crwa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crwa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crwa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [crwa_pkg::COUNT_BITS-1:0]  in_tick_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [crwa_pkg::RATE_W-1:0]      out_window_rate,
  output logic                             out_rate_valid,
  output logic                             out_report_due,
  output logic                             out_window_done,
  output logic [crwa_pkg::LEVEL_W-1:0]     out_alarm_level,
  output logic                             out_alarm
);

  crwa_pkg::ctrl_cmd_t  cmd;
  crwa_pkg::dp_status_t sts;

  crwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  crwa_datapath #(
    .WINDOW_TICKS  (WINDOW_TICKS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tick_count   (in_tick_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_rate (out_window_rate),
    .out_rate_valid  (out_rate_valid),
    .out_report_due  (out_report_due),
    .out_window_done (out_window_done),
    .out_alarm_level (out_alarm_level),
    .out_alarm       (out_alarm)
  );

endmodule
